// File: rtl/core/pose_frame_deframer_unit_macros.svh
// ----------------------------------------------------------------------------
// Pose frame deframer assertion macros
// Shared assertion forms for the deframer; clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef POSE_FRAME_DEFRAMER_UNIT_MACROS_SVH
`define POSE_FRAME_DEFRAMER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pfd_pkg.sv
// ----------------------------------------------------------------------------
// Pose frame deframer package
// Frame geometry, field widths and the types shared by the deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfd_pkg;

  localparam int VALUE_COUNT     = 7;
  localparam int BYTES_PER_VALUE = 4;
  localparam int WORD_W          = 32;
  localparam int BYTE_W          = 8;
  localparam int WORD_BYTES      = VALUE_COUNT * BYTES_PER_VALUE;
  localparam int COUNT_MAX       = 31;
  localparam int COUNT_W         = 5;
  localparam int BSEL_W          = 2;
  localparam int IDX_W           = 3;
  localparam int OUT_DATA_W      = VALUE_COUNT * WORD_W;
  localparam int OUT_USER_W      = 3;

  localparam logic [WORD_W-1:0] SIGN_MASK = 32'h8000_0000;

  typedef struct packed {
    logic [VALUE_COUNT-1:0][WORD_W-1:0] words;
    logic                               checksum_ok;
  } frame_t;

  typedef struct packed {
    logic push;
    frame_t frame;
  } front_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic is_nan(input logic [WORD_W-1:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

endpackage

// File: rtl/core/pfd_front.sv
// ----------------------------------------------------------------------------
// Pose frame deframer front end
// Takes bytes, assembles the seven words, counts and sums the burst and
// classifies each burst end as a frame or a drop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_front
  import pfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [BYTE_W-1:0]     byte_i,
  input  logic                  last_i,
  output front_out_t            front_o
);

  localparam logic [COUNT_W-1:0] WordBytes = COUNT_W'(WORD_BYTES);
  localparam logic [COUNT_W-1:0] CountMax  = COUNT_W'(COUNT_MAX);

  logic [VALUE_COUNT-1:0][WORD_W-1:0] word_q;
  logic [COUNT_W-1:0]                 count_q, count_d;
  logic [BYTE_W-1:0]                  sum_q, sum_d;
  logic                               in_words;
  logic [IDX_W-1:0]                   widx;
  logic [BSEL_W-1:0]                  bsel;

  assign in_words = (count_q < WordBytes);
  assign widx     = count_q[COUNT_W-1:BSEL_W];
  assign bsel     = count_q[BSEL_W-1:0];

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept_i) begin
      if (last_i) begin
        count_d = '0;
        sum_d   = '0;
      end else begin
        count_d = (count_q < CountMax) ? count_q + COUNT_W'(1) : CountMax;
        if (in_words) begin
          sum_d = sum_q + byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && in_words) begin
      word_q[widx][{bsel, 3'b000} +: BYTE_W] <= byte_i;
    end
  end

  assign front_o.push              = accept_i && last_i && (count_q == WordBytes);
  assign front_o.frame.words       = word_q;
  assign front_o.frame.checksum_ok = (sum_q == byte_i);

endmodule

// File: rtl/core/pfd_queue.sv
// ----------------------------------------------------------------------------
// Pose frame deframer queue
// Two-entry frame queue that decouples the front end from the result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_queue
  import pfd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  front_out_t    front_i,
  input  logic          pop_i,
  output frame_t        head_o,
  output queue_status_t status_o
);

  frame_t     entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign head_o         = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (front_i.push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (front_i.push && !pop_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (!front_i.push && pop_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (front_i.push) begin
      entry_q[wr_ptr_q] <= front_i.frame;
    end
  end

endmodule

// File: rtl/core/pfd_back.sv
// ----------------------------------------------------------------------------
// Pose frame deframer result stage
// Remaps the axes, checks for NaN words, marks the first frame and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfd_back
  import pfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  frame_t                head_i,
  input  queue_status_t         status_i,
  output logic                  pop_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [OUT_DATA_W-1:0] data_o,
  output logic [OUT_USER_W-1:0] user_o
);

  logic                  valid_q;
  logic                  ref_set_q;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic [OUT_USER_W-1:0] user_q, user_d;
  logic                  nums;

  assign pop_o = !status_i.empty && (!valid_q || ready_i);

  always_comb begin
    nums = 1'b1;
    for (int i = 0; i < VALUE_COUNT; i++) begin
      if (is_nan(head_i.words[i])) begin
        nums = 1'b0;
      end
    end
    data_d = {head_i.words[4],
              head_i.words[3] ^ SIGN_MASK,
              head_i.words[5] ^ SIGN_MASK,
              head_i.words[6],
              head_i.words[1],
              head_i.words[0] ^ SIGN_MASK,
              head_i.words[2] ^ SIGN_MASK};
    user_d = {!ref_set_q, nums, head_i.checksum_ok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      ref_set_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q   <= 1'b1;
        ref_set_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      user_q <= user_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign user_o  = user_q;

endmodule

// File: rtl/core/pose_frame_deframer_unit.sv
// ----------------------------------------------------------------------------
// Pose frame deframer
// Turns a byte stream cut into read bursts into pose results.
// ----------------------------------------------------------------------------
// Channel   Dir  Word                 Fields (lowest bit first)
// s_axis    in   one byte             tdata: data_byte; tlast: burst_end
// m_axis    out  one pose result      tdata: pos_x, pos_y, pos_z, quat_w,
//                                     quat_x, quat_y, quat_z;
//                                     tuser: checksum_ok, all_numbers, first_pose
//
// One byte is taken every cycle unless the input is stalled. A result is
// offered once the last byte of a 29-byte burst has passed the two-entry
// frame queue and then the output register. Reset clears all control state
// at once; no clearing pass follows. The input stalls only while both queue
// entries hold frames that the output side has not yet taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pose_frame_deframer_unit_macros.svh"

module pose_frame_deframer_unit
  import pfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [BYTE_W-1:0]     s_axis_tdata_i,   // data_byte
  input  logic                  s_axis_tlast_i,   // burst_end
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // pos_x..z, quat_w, quat_x..z
  output logic [OUT_USER_W-1:0] m_axis_tuser_o    // checksum_ok, all_numbers, first_pose
);

  logic          accept;
  logic          pop;
  front_out_t    front;
  frame_t        head;
  queue_status_t status;
  logic          first_taken;
  logic          first_shown;

  assign s_axis_tready_o = !status.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign first_shown     = m_axis_tvalid_o && m_axis_tuser_o[2];
  assign first_taken     = first_shown && m_axis_tready_i;

  pfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .front_o  (front)
  );

  pfd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .front_i  (front),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  pfd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (status),
    .pop_o    (pop),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .data_o   (m_axis_tdata_o),
    .user_o   (m_axis_tuser_o)
  );

  `PFD_ASSERT_SAME(a_push_has_room, front.push, !status.full, "Frame pushed into a full queue")
  `PFD_ASSERT_SAME(a_pop_not_empty, pop, !status.empty, "Frame popped from an empty queue")
  `PFD_ASSERT_NEXT(a_pop_shows_result, pop, m_axis_tvalid_o, "Popped frame not offered")
  `PFD_ASSERT_NEXT(a_first_once, first_taken, !first_shown, "First frame flag seen twice")

endmodule

// File: tb/sv/tb_pose_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pose frame deframer testbench
// Drives byte bursts into the deframer and checks every pose word that comes
// out against a local prediction of the frame assembly, the axis remapping
// and the three status flags, under random input gaps and output stalls.
// ----------------------------------------------------------------------------

module tb_pose_frame_deframer_unit;
  import pfd_pkg::*;

  localparam int FRAME_LEN    = WORD_BYTES + 1;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_HALF,
    RX_SPARSE
  } rx_mode_e;

  typedef struct {
    logic [VALUE_COUNT-1:0][WORD_W-1:0] words;
    logic                               checksum_ok;
    logic                               all_numbers;
    logic                               first_pose;
  } pose_result_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [BYTE_W-1:0]     s_axis_tdata_i  = '0;
  logic                  s_axis_tlast_i  = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [OUT_USER_W-1:0] m_axis_tuser_o;

  // Local copy of the deframer state.
  logic [WORD_W-1:0]  word_store [VALUE_COUNT];
  logic [COUNT_W-1:0] byte_count;
  logic [BYTE_W-1:0]  byte_sum;
  logic [BYTE_W-1:0]  last_byte;
  logic               reference_set;

  pose_result_t pending_poses [$];
  int           items_sent      = 0;
  int           error_count     = 0;
  int           cycle_count     = 0;

  bit gaps_on    = 1'b1;
  int burst_left = 0;

  int       hold_token  = 0;
  int       hold_len    = 0;
  int       hold_served = 0;
  int       hold_left   = 0;
  int       mode_left   = 0;
  rx_mode_e rx_mode     = RX_ALWAYS;

  string pose_field_names [VALUE_COUNT] =
    '{"pos_x", "pos_y", "pos_z", "quat_w", "quat_x", "quat_y", "quat_z"};

  pose_frame_deframer_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_deframer_state();
    for (int i = 0; i < VALUE_COUNT; i++) begin
      word_store[i] = '0;
    end
    byte_count    = '0;
    byte_sum      = '0;
    last_byte     = '0;
    reference_set = 1'b0;
  endfunction

  function automatic bit word_is_nan(input logic [WORD_W-1:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

  function automatic void deframe_byte(input logic [BYTE_W-1:0] b, input bit is_end);
    int           pos;
    int           count;
    pose_result_t pose;
    pos = byte_count;
    if (pos < WORD_BYTES) begin
      word_store[pos / BYTES_PER_VALUE][(pos % BYTES_PER_VALUE) * BYTE_W +: BYTE_W] = b;
      byte_sum = byte_sum + b;
    end else if (pos == WORD_BYTES) begin
      last_byte = b;
    end
    count      = (pos < COUNT_MAX) ? pos + 1 : COUNT_MAX;
    byte_count = COUNT_W'(count);
    if (is_end) begin
      byte_count = '0;
      if (count == FRAME_LEN) begin
        pose.words[0]    = word_store[2] ^ SIGN_MASK;
        pose.words[1]    = word_store[0] ^ SIGN_MASK;
        pose.words[2]    = word_store[1];
        pose.words[3]    = word_store[6];
        pose.words[4]    = word_store[5] ^ SIGN_MASK;
        pose.words[5]    = word_store[3] ^ SIGN_MASK;
        pose.words[6]    = word_store[4];
        pose.checksum_ok = (byte_sum == last_byte);
        pose.all_numbers = 1'b1;
        for (int i = 0; i < VALUE_COUNT; i++) begin
          if (word_is_nan(word_store[i])) begin
            pose.all_numbers = 1'b0;
          end
        end
        pose.first_pose = !reference_set;
        reference_set   = 1'b1;
        pending_poses.push_back(pose);
      end
      byte_sum = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit is_end);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= is_end;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    deframe_byte(b, is_end);
  endtask

  task automatic send_frame(input logic [VALUE_COUNT-1:0][WORD_W-1:0] w, input bit good_ck);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    sum = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      b   = w[i / BYTES_PER_VALUE][(i % BYTES_PER_VALUE) * BYTE_W +: BYTE_W];
      sum = sum + b;
      send_byte(b, 1'b0);
    end
    send_byte(good_ck ? sum : sum ^ BYTE_W'($urandom_range(1, 255)), 1'b1);
  endtask

  task automatic send_noise_burst(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(BYTE_W'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_poses.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    logic [WORD_W-1:0] w;
    w = $urandom;
    case ($urandom_range(0, 7))
      0: w = {w[31], 8'hFF, 23'd0};
      1: w = {w[31], 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      2: w = {w[31], 31'd0};
      3: w = '1;
      4: w = {w[31], 8'h00, w[22:0]};
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_random_frame(input bit good_ck);
    logic [VALUE_COUNT-1:0][WORD_W-1:0] w;
    for (int i = 0; i < VALUE_COUNT; i++) begin
      w[i] = pick_word();
    end
    send_frame(w, good_ck);
  endtask

  task automatic test_directed_bursts();
    logic [VALUE_COUNT-1:0][WORD_W-1:0] w;
    w[0] = 32'h0000_0000;
    w[1] = 32'h8000_0000;
    w[2] = 32'h7F80_0000;
    w[3] = 32'hFF80_0000;
    w[4] = 32'h0000_0001;
    w[5] = 32'h7F7F_FFFF;
    w[6] = 32'h3F80_0000;
    send_frame(w, 1'b1);
    send_noise_burst(1);
    send_noise_burst(33);
    w = '1;
    send_frame(w, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_full_queue_stall();
    gaps_on  = 1'b0;
    hold_len = 300;
    hold_token++;
    for (int i = 0; i < 4; i++) begin
      send_random_frame(1'b1);
    end
    gaps_on = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int start_items;
    int pick;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        gaps_on = !gaps_on;
      end
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        send_random_frame(pick != 6);
      end else if (pick <= 8) begin
        send_noise_burst($urandom_range(1, 40));
      end else begin
        wait_for_drain();
        send_random_frame(1'b1);
      end
    end
  endtask

  initial begin
    clear_deframer_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_bursts();
    test_full_queue_stall();
    test_random_traffic();
    wait_for_drain();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_token != hold_served) begin
      hold_served = hold_token;
      hold_left   = hold_len;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: m_axis_tready_i <= 1'b1;
        RX_MOSTLY: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        RX_HALF:   m_axis_tready_i <= ($urandom_range(0, 1) != 0);
        default:   m_axis_tready_i <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_pose_words
    pose_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_poses.size() == 0) begin
        report_mismatch("pose word with none pending", m_axis_tdata_o[WORD_W-1:0], '0);
      end else begin
        want = pending_poses.pop_front();
        for (int i = 0; i < VALUE_COUNT; i++) begin
          if (m_axis_tdata_o[i * WORD_W +: WORD_W] !== want.words[i]) begin
            report_mismatch(pose_field_names[i], m_axis_tdata_o[i * WORD_W +: WORD_W],
                            want.words[i]);
          end
        end
        if (m_axis_tuser_o[0] !== want.checksum_ok) begin
          report_mismatch("checksum_ok", WORD_W'(m_axis_tuser_o[0]), WORD_W'(want.checksum_ok));
        end
        if (m_axis_tuser_o[1] !== want.all_numbers) begin
          report_mismatch("all_numbers", WORD_W'(m_axis_tuser_o[1]), WORD_W'(want.all_numbers));
        end
        if (m_axis_tuser_o[2] !== want.first_pose) begin
          report_mismatch("first_pose", WORD_W'(m_axis_tuser_o[2]), WORD_W'(want.first_pose));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// File: pose_frame_deframer_unit.f
+incdir+rtl/core
rtl/core/pfd_pkg.sv
rtl/core/pfd_front.sv
rtl/core/pfd_queue.sv
rtl/core/pfd_back.sv
rtl/core/pose_frame_deframer_unit.sv
tb/sv/tb_pose_frame_deframer_unit.sv
